// ----- rtl/vmf3d_pkg.sv -----
package vmf3d_pkg;

  // Window geometry: the cube is indexed dz*9 + dy*3 + dx, each axis counted
  // as steps back from the newest voxel.
  localparam int unsigned WinSize  = 27;
  localparam int unsigned CubeMid  = 13;
  localparam int unsigned CrossMid = 3;

  // The cross keeps the center and its six face neighbors.
  localparam logic [WinSize-1:0] CrossMask = 27'h0417410;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_SLICES  = 2'd2,
    CFG_MODE    = 2'd3
  } cfg_idx_e;

  // Flags that travel with each beat down the pipeline.
  typedef struct packed {
    logic emit;
    logic last;
  } beat_flags_t;

endpackage

// ----- rtl/vmf3d_ram.sv -----
module vmf3d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and a write at the same entry return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/volume_median_filter_3d_core.sv -----
// A result beat follows the voxel that completes its window through all stages.
// Throughput: one voxel per cycle; the pipeline stalls only while the output
// register holds a beat that is not taken.
// Plane delay lives in two plane RAMs, row delay in six row RAMs, one port each.
// Reset clears position counters, valid bits and configuration (512x512x3, cross);
// the delay RAMs need no clearing. A configuration write restarts the volume.
module volume_median_filter_3d_core #(
  parameter int unsigned MAX_COLS     = 512,
  parameter int unsigned MAX_ROWS     = 512,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] voxel_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] median_value_o,
  output logic        is_last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned NW    = vmf3d_pkg::WinSize;
  localparam int unsigned COLW  = $clog2(MAX_COLS);
  localparam int unsigned ROWW  = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned PLANE = MAX_COLS * MAX_ROWS;
  localparam int unsigned PAW   = $clog2(PLANE);

  // Configuration registers.
  logic [9:0]  cfg_cols_q, cfg_rows_q;
  logic [15:0] cfg_slices_q;
  logic        cfg_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q   <= 10'd512;
      cfg_rows_q   <= 10'd512;
      cfg_slices_q <= 16'd3;
      cfg_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (vmf3d_pkg::cfg_idx_e'(cfg_index_i))
        vmf3d_pkg::CFG_COLUMNS: cfg_cols_q   <= cfg_data_i[9:0];
        vmf3d_pkg::CFG_ROWS:    cfg_rows_q   <= cfg_data_i[9:0];
        vmf3d_pkg::CFG_SLICES:  cfg_slices_q <= cfg_data_i;
        vmf3d_pkg::CFG_MODE:    cfg_mode_q   <= cfg_data_i[0];
        default:                cfg_mode_q   <= cfg_mode_q;
      endcase
    end
  end

  // Effective dimensions after clamping.
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  logic [15:0]   slices_eff;

  always_comb begin
    if (cfg_cols_q < 10'd3) begin
      cols_eff = CW'(3);
    end else if (32'(cfg_cols_q) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cfg_cols_q);
    end
    if (cfg_rows_q < 10'd3) begin
      rows_eff = RW'(3);
    end else if (32'(cfg_rows_q) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(cfg_rows_q);
    end
    slices_eff = (cfg_slices_q < 16'd3) ? 16'd3 : cfg_slices_q;
  end

  logic [NW-1:0] win_mask;
  assign win_mask = cfg_mode_q ? {NW{1'b1}} : vmf3d_pkg::CrossMask;

  // Handshake: the whole pipeline moves unless the output beat is stuck.
  logic out_valid_q;
  logic adv, accept;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Position counters.
  logic [COLW-1:0] col_q;
  logic [ROWW-1:0] row_q;
  logic [15:0]     slice_q;
  logic [PAW-1:0]  paddr_q;
  logic            col_end, row_end, slice_end;

  assign col_end   = (CW'(col_q) == cols_eff - CW'(1));
  assign row_end   = (RW'(row_q) == rows_eff - RW'(1));
  assign slice_end = (slice_q == slices_eff - 16'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slice_q <= '0;
      paddr_q <= '0;
    end else if (cfg_we_i) begin
      col_q   <= '0;
      row_q   <= '0;
      slice_q <= '0;
      paddr_q <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q   <= '0;
          paddr_q <= '0;
          slice_q <= slice_end ? 16'd0 : slice_q + 16'd1;
        end else begin
          row_q   <= row_q + ROWW'(1);
          paddr_q <= paddr_q + PAW'(1);
        end
      end else begin
        col_q   <= col_q + COLW'(1);
        paddr_q <= paddr_q + PAW'(1);
      end
    end
  end

  vmf3d_pkg::beat_flags_t flags0;
  assign flags0.emit = (col_q >= COLW'(2)) && (row_q >= ROWW'(2)) && (slice_q >= 16'd2);
  assign flags0.last = col_end && row_end && slice_end;

  logic [SW-1:0] sample0;
  assign sample0 = SW'({32'd0, voxel_value_i});

  // Pipeline registers.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  vmf3d_pkg::beat_flags_t f1_q, f2_q, f3_q, f4_q, f5_q, f6_q, f7_q;
  logic [SW-1:0]   s1_q;
  logic [PAW-1:0]  a1_q;
  logic [COLW-1:0] c1_q, c2_q, c3_q;
  logic [SW-1:0]   z0_2_q, z1_2_q;
  logic [SW-1:0]   z3_q [3];
  logic [SW-1:0]   z4_q [3];
  logic [SW-1:0]   y4_q [3];
  logic [SW-1:0]   sh1_q [9];
  logic [SW-1:0]   sh2_q [9];
  logic [SW-1:0]   win5_q [NW];
  logic [SW-1:0]   val6_q [NW];
  logic [SW-1:0]   val7_q [NW];
  logic [NW-1:0]   m6_q [NW];
  logic [3:0]      cnt7_q [NW][3];

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // Plane delays: one and two slices back.
  logic [SW-1:0] pl1_rd, pl2_rd;

  vmf3d_ram #(.WIDTH(SW), .DEPTH(PLANE)) u_plane1 (
    .clk_i  (clk_i),
    .we_i   (accept),
    .re_i   (adv),
    .addr_i (paddr_q),
    .wdata_i(sample0),
    .rdata_o(pl1_rd)
  );

  vmf3d_ram #(.WIDTH(SW), .DEPTH(PLANE)) u_plane2 (
    .clk_i  (clk_i),
    .we_i   (adv && v1_q),
    .re_i   (adv),
    .addr_i (a1_q),
    .wdata_i(pl1_rd),
    .rdata_o(pl2_rd)
  );

  // Row delays for each slice stream.
  logic [SW-1:0] z2_stream [3];
  logic [SW-1:0] rowa_rd [3];
  logic [SW-1:0] rowb_rd [3];

  assign z2_stream[0] = z0_2_q;
  assign z2_stream[1] = z1_2_q;
  assign z2_stream[2] = pl2_rd;

  for (genvar g = 0; g < 3; g++) begin : g_rows
    vmf3d_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_rowa (
      .clk_i  (clk_i),
      .we_i   (adv && v2_q),
      .re_i   (adv),
      .addr_i (c2_q),
      .wdata_i(z2_stream[g]),
      .rdata_o(rowa_rd[g])
    );
    vmf3d_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_rowb (
      .clk_i  (clk_i),
      .we_i   (adv && v3_q),
      .re_i   (adv),
      .addr_i (c3_q),
      .wdata_i(rowa_rd[g]),
      .rdata_o(rowb_rd[g])
    );
  end

  // Nine row streams at the window stage and the gathered window.
  logic [SW-1:0] strm [9];
  logic [SW-1:0] win4 [NW];

  always_comb begin
    for (int dz = 0; dz < 3; dz++) begin
      strm[dz*3]     = z4_q[dz];
      strm[dz*3 + 1] = y4_q[dz];
      strm[dz*3 + 2] = rowb_rd[dz];
    end
    for (int k = 0; k < 9; k++) begin
      win4[k*3]     = strm[k];
      win4[k*3 + 1] = sh1_q[k];
      win4[k*3 + 2] = sh2_q[k];
    end
  end

  // Pairwise rank bits: element j counts below element i.
  logic [NW-1:0] m5 [NW];
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      for (int j = 0; j < NW; j++) begin
        if (j < i) begin
          m5[i][j] = (win5_q[j] <= win5_q[i]) && win_mask[j];
        end else if (j > i) begin
          m5[i][j] = (win5_q[j] < win5_q[i]) && win_mask[j];
        end else begin
          m5[i][j] = 1'b0;
        end
      end
    end
  end

  // Partial counts over three groups of nine.
  logic [3:0] cnt6 [NW][3];
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      for (int g = 0; g < 3; g++) begin
        cnt6[i][g] = '0;
        for (int j = 0; j < 9; j++) begin
          cnt6[i][g] = cnt6[i][g] + 4'(m6_q[i][g*9 + j]);
        end
      end
    end
  end

  // Rank total and median select.
  logic [4:0]    mid;
  logic [4:0]    rank7 [NW];
  logic [NW-1:0] sel7;
  logic [SW-1:0] med7;
  assign mid = cfg_mode_q ? 5'(vmf3d_pkg::CubeMid) : 5'(vmf3d_pkg::CrossMid);

  always_comb begin
    med7 = '0;
    for (int i = 0; i < NW; i++) begin
      rank7[i] = 5'(cnt7_q[i][0]) + 5'(cnt7_q[i][1]) + 5'(cnt7_q[i][2]);
      sel7[i]  = win_mask[i] && (rank7[i] == mid);
      med7     = med7 | (val7_q[i] & {SW{sel7[i]}});
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= sample0;
      a1_q   <= paddr_q;
      c1_q   <= col_q;
      f1_q   <= flags0;
      z0_2_q <= s1_q;
      z1_2_q <= pl1_rd;
      c2_q   <= c1_q;
      f2_q   <= f1_q;
      for (int g = 0; g < 3; g++) begin
        z3_q[g] <= z2_stream[g];
        z4_q[g] <= z3_q[g];
        y4_q[g] <= rowa_rd[g];
      end
      c3_q <= c2_q;
      f3_q <= f2_q;
      f4_q <= f3_q;
      if (v4_q) begin
        for (int k = 0; k < 9; k++) begin
          sh1_q[k] <= strm[k];
          sh2_q[k] <= sh1_q[k];
        end
      end
      win5_q <= win4;
      f5_q   <= f4_q;
      val6_q <= win5_q;
      m6_q   <= m5;
      f6_q   <= f5_q;
      val7_q <= val6_q;
      cnt7_q <= cnt6;
      f7_q   <= f6_q;
    end
  end

  // Output register.
  logic [SW-1:0] med_q;
  logic          last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v7_q && f7_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      med_q  <= med7;
      last_q <= f7_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = 16'({32'd0, med_q});
  assign is_last_o      = last_q;

  // A configuration write restarts the volume at the origin.
  a_cfg_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0) && (slice_q == '0))
    else $error("position not cleared by configuration write");

  // The column counter stays inside the row.
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> (CW'(col_q) < cols_eff))
    else $error("column position beyond row length");

  // Exactly one window element holds the median rank.
  a_one_median : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && f7_q.emit) |-> $onehot(sel7))
    else $error("median select not one-hot");

  // A beat that was stalled keeps its value.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(med_q) && $stable(last_q))
    else $error("stalled result changed");

endmodule

// ----- tb/tb_volume_median_filter_3d_core.sv -----
`timescale 1ns / 100ps

module tb_volume_median_filter_3d_core;

  typedef struct {
    logic [15:0] median;
    logic        last;
  } median_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] voxel_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] median_value_o;
  logic        is_last_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  volume_median_filter_3d_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .voxel_value_i  (voxel_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_value_o (median_value_o),
    .is_last_o      (is_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Voxels waiting to be sent and medians waiting to come back.
  logic [15:0]  voxel_queue[$];
  median_beat_t median_queue[$];

  // Shadow of the block: configuration, positions and the voxels since restart.
  logic [9:0]  shadow_columns;
  logic [9:0]  shadow_rows;
  logic [15:0] shadow_slices;
  logic        shadow_cube;
  int unsigned col_at;
  int unsigned row_at;
  int unsigned slice_at;
  logic [15:0] voxel_log[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned voxels_sent;
  int unsigned medians_seen;
  int unsigned lasts_seen;
  bit          long_hold_req;
  bit          long_hold_done;
  int unsigned hold_left;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Median of the window whose far corner is this voxel, if it is interior.
  function automatic void predict_median(logic [15:0] v);
    int unsigned cols;
    int unsigned rows;
    int unsigned slices;
    int unsigned back_dist;
    int unsigned off_axes;
    int          picked[$];
    median_beat_t beat;
    cols   = clamp_size(shadow_columns, 512);
    rows   = clamp_size(shadow_rows, 512);
    slices = clamp_size(shadow_slices, 65535);
    if (col_at >= 2 && row_at >= 2 && slice_at >= 2) begin
      for (int dz = 0; dz < 3; dz++) begin
        for (int dy = 0; dy < 3; dy++) begin
          for (int dx = 0; dx < 3; dx++) begin
            off_axes = (dx != 1) + (dy != 1) + (dz != 1);
            if (!shadow_cube && off_axes > 1) continue;
            back_dist = dx + dy * cols + dz * cols * rows;
            if (back_dist == 0) picked.push_back(v);
            else picked.push_back(voxel_log[voxel_log.size() - back_dist]);
          end
        end
      end
      picked.sort();
      beat.median = 16'(picked[shadow_cube ? vmf3d_pkg::CubeMid : vmf3d_pkg::CrossMid]);
      beat.last = (col_at == cols - 1 && row_at == rows - 1 && slice_at == slices - 1);
      median_queue.push_back(beat);
    end
    voxel_log.push_back(v);
    col_at++;
    if (col_at >= cols) begin
      col_at = 0;
      row_at++;
      if (row_at >= rows) begin
        row_at = 0;
        slice_at++;
        if (slice_at >= slices) slice_at = 0;
      end
    end
  endfunction

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cycle counter; each period of the count ends in a calm stretch without idling.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic bit idle_now();
    if ((cycle_count % 1500) >= 1200) return 1'b0;
    return ($urandom_range(0, 99) < 11);
  endfunction

  // Input driver: predicts on every accepted beat, then offers the next voxel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      voxel_value_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_median(voxel_value_i);
        voxels_sent++;
      end
      if (in_valid_i && !in_ready_o) begin
        // Hold the beat until it is taken.
      end else if (voxel_queue.size() > 0 && !idle_now()) begin
        in_valid_i <= 1'b1;
        voxel_value_i <= voxel_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: compares each beat with the oldest expected median.
  always @(posedge clk_i or negedge rst_ni) begin
    median_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        medians_seen++;
        if (is_last_o) lasts_seen++;
        if (median_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected beat: median %h last %b", median_value_o, is_last_o);
        end else begin
          want = median_queue.pop_front();
          if (want.median !== median_value_o || want.last !== is_last_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected median %h last %b, got median %h last %b",
                       want.median, want.last, median_value_o, is_last_o);
          end
        end
      end
      // A long hold-off is loaded once on request so the pipeline backs up.
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !idle_now();
      end
    end
  end

  // Wait until the block has drained, then allow for beats still in flight.
  task automatic wait_drained();
    while (voxel_queue.size() > 0 || in_valid_i || median_queue.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(vmf3d_pkg::cfg_idx_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      vmf3d_pkg::CFG_COLUMNS: shadow_columns = data[9:0];
      vmf3d_pkg::CFG_ROWS:    shadow_rows = data[9:0];
      vmf3d_pkg::CFG_SLICES:  shadow_slices = data;
      default:                shadow_cube = data[0];
    endcase
    col_at = 0;
    row_at = 0;
    slice_at = 0;
    voxel_log.delete();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_volume(logic [15:0] cols, logic [15:0] rows, logic [15:0] slices,
                            logic cube);
    wait_drained();
    write_reg(vmf3d_pkg::CFG_COLUMNS, cols);
    write_reg(vmf3d_pkg::CFG_ROWS, rows);
    write_reg(vmf3d_pkg::CFG_SLICES, slices);
    write_reg(vmf3d_pkg::CFG_MODE, {15'd0, cube});
  endtask

  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      voxel_queue.push_back(16'($urandom()));
  endtask

  // Ends a hung run.
  initial begin
    #(12 * 3000000);
    $display("FAILURE");
    $finish;
  end

  // Stimulus.
  initial begin
    int unsigned cols;
    int unsigned rows;
    int unsigned slices;
    int unsigned volume;
    int unsigned random_sent;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = vmf3d_pkg::CFG_COLUMNS;
    cfg_data_i = '0;
    cycle_count = 0;
    mismatch_count = 0;
    voxels_sent = 0;
    medians_seen = 0;
    lasts_seen = 0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    hold_left = 0;
    shadow_columns = 10'd512;
    shadow_rows = 10'd512;
    shadow_slices = 16'd3;
    shadow_cube = 1'b0;
    col_at = 0;
    row_at = 0;
    slice_at = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Smallest volume, sizes below three, extreme sample values.
    set_volume(16'd0, 16'd1, 16'd2, 1'b0);
    for (int i = 0; i < 27; i++)
      voxel_queue.push_back((i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'h8001));
    set_volume(16'd3, 16'd3, 16'd3, 1'b1);
    for (int i = 0; i < 27; i++)
      voxel_queue.push_back((i % 2) ? 16'hFFFF : 16'(i));

    // Maximum slice count: only a few slices are sent before a restart.
    set_volume(16'd4, 16'd4, 16'hFFFF, 1'b1);
    queue_random(16 * 5);

    // Random small volumes; one phase backs up the output for a long time.
    random_sent = 0;
    while (random_sent < 660) begin
      cols = $urandom_range(0, 9);
      rows = $urandom_range(0, 6);
      slices = $urandom_range(0, 5);
      set_volume(16'(cols), 16'(rows), 16'(slices), 1'($urandom_range(0, 1)));
      volume = clamp_size(cols, 512) * clamp_size(rows, 512) * clamp_size(slices, 65535);
      case ($urandom_range(0, 3))
        0:       volume = $urandom_range(1, volume);
        1:       volume = volume * 2;
        default: ;
      endcase
      if (random_sent > 200 && !long_hold_req && volume >= 100) long_hold_req = 1'b1;
      queue_random(volume);
      random_sent += volume;
    end

    wait_drained();
    $display("Sent %0d voxels over cross and cube windows, small and clamped sizes.",
             voxels_sent);
    $display("Checked %0d medians, %0d of them flagged last.", medians_seen, lasts_seen);
    if (mismatch_count == 0 && median_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vmf3d_pkg.sv
rtl/vmf3d_ram.sv
rtl/volume_median_filter_3d_core.sv
tb/tb_volume_median_filter_3d_core.sv
